// ===== sv/subscription_table_engine_defines.svh =====
// ----------------------------------------------------------------------------
// subscription table engine assertion macros
// concurrent checks clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SUBSCRIPTION_TABLE_ENGINE_DEFINES_SVH
`define SUBSCRIPTION_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication
`define STE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("subscription table engine: same-cycle check failed");

// next-cycle implication
`define STE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("subscription table engine: next-cycle check failed");

`endif

// ===== sv/ste_pkg.sv =====
// ----------------------------------------------------------------------------
// ste_pkg
// sizes, codes and controller/datapath interface types of the subscription table
// ----------------------------------------------------------------------------
package ste_pkg;

	// table sizes
	localparam int AUTHOR_SLOTS     = 256;
	localparam int EVENT_SLOTS      = 256;
	localparam int SUBSCRIBER_SLOTS = 1024;
	localparam int LABEL_BITS       = 16;
	localparam int ID_BITS          = 16;

	// index and link widths, a link equal to the pool size is null
	localparam int AIW = $clog2(AUTHOR_SLOTS);
	localparam int EIW = $clog2(EVENT_SLOTS);
	localparam int EPW = $clog2(EVENT_SLOTS + 1);
	localparam int SIW = $clog2(SUBSCRIBER_SLOTS);
	localparam int SPW = $clog2(SUBSCRIBER_SLOTS + 1);

	localparam logic [EPW-1:0] EV_NULL  = EPW'(EVENT_SLOTS);
	localparam logic [SPW-1:0] SUB_NULL = SPW'(SUBSCRIBER_SLOTS);

	// clearing pass covers the deepest table
	localparam int CLR_LEN_A = (AUTHOR_SLOTS > EVENT_SLOTS) ? AUTHOR_SLOTS : EVENT_SLOTS;
	localparam int CLR_LEN   = (CLR_LEN_A > SUBSCRIBER_SLOTS) ? CLR_LEN_A : SUBSCRIBER_SLOTS;
	localparam int CLW       = $clog2(CLR_LEN);

	// request codes
	localparam logic [1:0] REQ_SUBSCRIBE   = 2'd0;
	localparam logic [1:0] REQ_UNSUBSCRIBE = 2'd1;
	localparam logic [1:0] REQ_REMOVE      = 2'd2;

	typedef enum logic [2:0] {
		ST_DONE,
		ST_DUPLICATE,
		ST_EVENT_FULL,
		ST_SUB_FULL,
		ST_EVENT_ABSENT,
		ST_SUB_ABSENT
	} status_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_CLEAR,
		OP_LOAD,
		OP_EV_START,
		OP_EV_READ,
		OP_EV_NEXT,
		OP_EV_ALLOC,
		OP_EV_FILL,
		OP_EV_LINK,
		OP_SB_START,
		OP_SB_READ,
		OP_SB_NEXT,
		OP_SB_ALLOC,
		OP_SB_FILL,
		OP_SB_LINK,
		OP_SB_UNLINK,
		OP_SB_SPLICE,
		OP_RM_SB_START,
		OP_RM_SB_FREE,
		OP_RM_EV_FREE,
		OP_RM_FINISH,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic [1:0] req;
		logic       e_null;
		logic       label_match;
		logic       efree_null;
		logic       s_null;
		logic       id_match;
		logic       sfree_null;
		logic       out_full;
	} stat_t;

endpackage

// ===== sv/ste_ctrl.sv =====
// ----------------------------------------------------------------------------
// ste_ctrl
// request sequencer: walks the event and subscriber lists through the datapath
// ----------------------------------------------------------------------------
module ste_ctrl
	import ste_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HEAD,
		S_FIND,
		S_ECHK,
		S_EFILL,
		S_ELINK,
		S_SWALK,
		S_SCHK,
		S_SFILL,
		S_SLINK,
		S_SPLICE,
		S_RM_HEAD,
		S_RM_SWALK,
		S_RM_SFREE,
		S_RESULT
	} state_t;

	state_t  state_q, state_d;
	status_t code_q, code_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and datapath command
	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		cmd.op   = OP_NOP;
		cmd.code = code_q;
		case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				if (stat.req == REQ_SUBSCRIBE || stat.req == REQ_UNSUBSCRIBE ||
				    stat.req == REQ_REMOVE) begin
					cmd.op  = OP_EV_START;
					state_d = S_FIND;
				end else begin
					code_d  = ST_DONE;
					state_d = S_RESULT;
				end
			end
			S_FIND: begin
				if (stat.e_null) begin
					if (stat.req == REQ_REMOVE) begin
						cmd.op  = OP_RM_FINISH;
						code_d  = ST_DONE;
						state_d = S_RESULT;
					end else if (stat.req == REQ_UNSUBSCRIBE) begin
						code_d  = ST_EVENT_ABSENT;
						state_d = S_RESULT;
					end else if (stat.efree_null) begin
						code_d  = ST_EVENT_FULL;
						state_d = S_RESULT;
					end else begin
						cmd.op  = OP_EV_ALLOC;
						state_d = S_EFILL;
					end
				end else begin
					cmd.op  = OP_EV_READ;
					state_d = (stat.req == REQ_REMOVE) ? S_RM_HEAD : S_ECHK;
				end
			end
			S_ECHK: begin
				if (stat.label_match) begin
					cmd.op  = OP_SB_START;
					state_d = S_SWALK;
				end else begin
					cmd.op  = OP_EV_NEXT;
					state_d = S_FIND;
				end
			end
			S_EFILL: begin
				cmd.op  = OP_EV_FILL;
				state_d = S_ELINK;
			end
			S_ELINK: begin
				cmd.op  = OP_EV_LINK;
				state_d = S_SWALK;
			end
			S_SWALK: begin
				if (stat.s_null) begin
					if (stat.req == REQ_UNSUBSCRIBE) begin
						code_d  = ST_SUB_ABSENT;
						state_d = S_RESULT;
					end else if (stat.sfree_null) begin
						code_d  = ST_SUB_FULL;
						state_d = S_RESULT;
					end else begin
						cmd.op  = OP_SB_ALLOC;
						state_d = S_SFILL;
					end
				end else begin
					cmd.op  = OP_SB_READ;
					state_d = S_SCHK;
				end
			end
			S_SCHK: begin
				if (stat.id_match) begin
					if (stat.req == REQ_UNSUBSCRIBE) begin
						cmd.op  = OP_SB_UNLINK;
						state_d = S_SPLICE;
					end else begin
						code_d  = ST_DUPLICATE;
						state_d = S_RESULT;
					end
				end else begin
					cmd.op  = OP_SB_NEXT;
					state_d = S_SWALK;
				end
			end
			S_SFILL: begin
				cmd.op  = OP_SB_FILL;
				state_d = S_SLINK;
			end
			S_SLINK: begin
				cmd.op  = OP_SB_LINK;
				code_d  = ST_DONE;
				state_d = S_RESULT;
			end
			S_SPLICE: begin
				cmd.op  = OP_SB_SPLICE;
				code_d  = ST_DONE;
				state_d = S_RESULT;
			end
			S_RM_HEAD: begin
				cmd.op  = OP_RM_SB_START;
				state_d = S_RM_SWALK;
			end
			S_RM_SWALK: begin
				if (stat.s_null) begin
					cmd.op  = OP_RM_EV_FREE;
					state_d = S_FIND;
				end else begin
					cmd.op  = OP_SB_READ;
					state_d = S_RM_SFREE;
				end
			end
			S_RM_SFREE: begin
				cmd.op  = OP_RM_SB_FREE;
				state_d = S_RM_SWALK;
			end
			S_RESULT: begin
				if (!stat.out_full) begin
					cmd.op  = OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// state and result code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			code_q  <= ST_DONE;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

// ===== sv/ste_datapath.sv =====
// ----------------------------------------------------------------------------
// ste_datapath
// list tables, free list heads, walk pointers and the result register
// ----------------------------------------------------------------------------
module ste_datapath
	import ste_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  cmd_t            cmd,
	output stat_t           stat,
	input  logic [1:0]      in_req,
	input  logic [7:0]      in_author,
	input  logic [15:0]     in_label,
	input  logic [15:0]     in_id,
	input  logic            in_inform,
	input  logic            out_ready,
	output logic            out_valid,
	output logic [2:0]      out_status,
	output logic            out_notify,
	output logic [7:0]      out_index,
	output logic [15:0]     out_source
);

	// tables
	logic [EPW-1:0]        ahead_mem   [AUTHOR_SLOTS];
	logic [LABEL_BITS-1:0] elabel_mem  [EVENT_SLOTS];
	logic [EPW-1:0]        elink_mem   [EVENT_SLOTS];
	logic [SPW-1:0]        eshead_mem  [EVENT_SLOTS];
	logic [ID_BITS-1:0]    sid_mem     [SUBSCRIBER_SLOTS];
	logic [SPW-1:0]        slink_mem   [SUBSCRIBER_SLOTS];

	// registered read data
	logic [EPW-1:0]        ahead_rd_q;
	logic [LABEL_BITS-1:0] elabel_rd_q;
	logic [EPW-1:0]        elink_rd_q;
	logic [SPW-1:0]        eshead_rd_q;
	logic [ID_BITS-1:0]    sid_rd_q;
	logic [SPW-1:0]        slink_rd_q;

	// request and walk registers
	logic [1:0]            req_q;
	logic [AIW-1:0]        a_q;
	logic [LABEL_BITS-1:0] label_q;
	logic [ID_BITS-1:0]    id_q;
	logic                  inform_q;
	logic [EPW-1:0]        e_q, prev_e_q, efree_q;
	logic [SPW-1:0]        s_q, prev_s_q, sfree_q;
	logic [CLW-1:0]        clr_q;
	logic                  out_valid_q;
	logic [2:0]            out_status_q;
	logic                  out_notify_q;
	logic [7:0]            out_index_q;
	logic [15:0]           out_source_q;

	// write ports
	logic                  ahead_we, elabel_we, elink_we, eshead_we, sid_we, slink_we;
	logic [AIW-1:0]        ahead_wa;
	logic [EIW-1:0]        elabel_wa, elink_wa, eshead_wa;
	logic [SIW-1:0]        sid_wa, slink_wa;
	logic [EPW-1:0]        ahead_wd, elink_wd;
	logic [SPW-1:0]        eshead_wd, slink_wd;
	logic                  notify;

	wire logic [EIW-1:0] e_idx    = e_q[EIW-1:0];
	wire logic [SIW-1:0] s_idx    = s_q[SIW-1:0];
	wire logic [EIW-1:0] clr_eidx = clr_q[EIW-1:0];
	wire logic [SIW-1:0] clr_sidx = clr_q[SIW-1:0];

	// status toward the controller
	always_comb begin
		stat.clr_last    = (clr_q == CLW'(CLR_LEN - 1));
		stat.req         = req_q;
		stat.e_null      = (e_q == EV_NULL);
		stat.label_match = (elabel_rd_q == label_q);
		stat.efree_null  = (efree_q == EV_NULL);
		stat.s_null      = (s_q == SUB_NULL);
		stat.id_match    = (sid_rd_q == id_q);
		stat.sfree_null  = (sfree_q == SUB_NULL);
		stat.out_full    = out_valid_q;
	end

	// write port selection
	always_comb begin
		ahead_we  = 1'b0; ahead_wa  = a_q;       ahead_wd  = EV_NULL;
		elabel_we = 1'b0; elabel_wa = e_idx;
		elink_we  = 1'b0; elink_wa  = e_idx;     elink_wd  = EV_NULL;
		eshead_we = 1'b0; eshead_wa = e_idx;     eshead_wd = SUB_NULL;
		sid_we    = 1'b0; sid_wa    = s_idx;
		slink_we  = 1'b0; slink_wa  = s_idx;     slink_wd  = SUB_NULL;
		case (cmd.op)
			OP_CLEAR: begin
				ahead_we  = (clr_q < AUTHOR_SLOTS);
				ahead_wa  = clr_q[AIW-1:0];
				elink_we  = (clr_q < EVENT_SLOTS);
				elink_wa  = clr_eidx;
				elink_wd  = EPW'(clr_eidx) + EPW'(1);
				eshead_we = (clr_q < EVENT_SLOTS);
				eshead_wa = clr_eidx;
				slink_we  = (clr_q < SUBSCRIBER_SLOTS);
				slink_wa  = clr_sidx;
				slink_wd  = SPW'(clr_sidx) + SPW'(1);
			end
			OP_EV_FILL: begin
				elabel_we = 1'b1;
				elink_we  = 1'b1;
				eshead_we = 1'b1;
			end
			OP_EV_LINK: begin
				if (prev_e_q == EV_NULL) begin
					ahead_we = 1'b1;
					ahead_wd = e_q;
				end else begin
					elink_we = 1'b1;
					elink_wa = prev_e_q[EIW-1:0];
					elink_wd = e_q;
				end
			end
			OP_SB_FILL: begin
				sid_we   = 1'b1;
				slink_we = 1'b1;
			end
			OP_SB_LINK: begin
				if (prev_s_q == SUB_NULL) begin
					eshead_we = 1'b1;
					eshead_wd = s_q;
				end else begin
					slink_we = 1'b1;
					slink_wa = prev_s_q[SIW-1:0];
					slink_wd = s_q;
				end
			end
			OP_SB_UNLINK, OP_RM_SB_FREE: begin
				slink_we = 1'b1;
				slink_wd = sfree_q;
			end
			OP_SB_SPLICE: begin
				if (prev_s_q == SUB_NULL) begin
					eshead_we = 1'b1;
					eshead_wd = slink_rd_q;
				end else begin
					slink_we = 1'b1;
					slink_wa = prev_s_q[SIW-1:0];
					slink_wd = slink_rd_q;
				end
			end
			OP_RM_SB_START: begin
				eshead_we = 1'b1;
			end
			OP_RM_EV_FREE: begin
				elink_we = 1'b1;
				elink_wd = efree_q;
			end
			OP_RM_FINISH: begin
				ahead_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// author heads
	always_ff @(posedge clk) begin
		if (ahead_we) ahead_mem[ahead_wa] <= ahead_wd;
		if (cmd.op == OP_LOAD) ahead_rd_q <= ahead_mem[in_author[AIW-1:0]];
	end

	// event labels
	always_ff @(posedge clk) begin
		if (elabel_we) elabel_mem[elabel_wa] <= label_q;
		if (cmd.op == OP_EV_READ) elabel_rd_q <= elabel_mem[e_idx];
	end

	// event links
	always_ff @(posedge clk) begin
		if (elink_we) elink_mem[elink_wa] <= elink_wd;
		if (cmd.op == OP_EV_READ) elink_rd_q <= elink_mem[e_idx];
		else if (cmd.op == OP_EV_ALLOC) elink_rd_q <= elink_mem[efree_q[EIW-1:0]];
	end

	// subscriber list heads
	always_ff @(posedge clk) begin
		if (eshead_we) eshead_mem[eshead_wa] <= eshead_wd;
		if (cmd.op == OP_EV_READ) eshead_rd_q <= eshead_mem[e_idx];
	end

	// subscriber ids
	always_ff @(posedge clk) begin
		if (sid_we) sid_mem[sid_wa] <= id_q;
		if (cmd.op == OP_SB_READ) sid_rd_q <= sid_mem[s_idx];
	end

	// subscriber links
	always_ff @(posedge clk) begin
		if (slink_we) slink_mem[slink_wa] <= slink_wd;
		if (cmd.op == OP_SB_READ) slink_rd_q <= slink_mem[s_idx];
		else if (cmd.op == OP_SB_ALLOC) slink_rd_q <= slink_mem[sfree_q[SIW-1:0]];
	end

	assign notify = (req_q == REQ_SUBSCRIBE) && (cmd.code == ST_DONE) && inform_q;

	// free heads, clear counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			efree_q     <= '0;
			sfree_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_CLEAR:      clr_q       <= clr_q + CLW'(1);
				OP_EV_FILL:    efree_q     <= elink_rd_q;
				OP_RM_EV_FREE: efree_q     <= e_q;
				OP_SB_FILL:    sfree_q     <= slink_rd_q;
				OP_SB_UNLINK:  sfree_q     <= s_q;
				OP_RM_SB_FREE: sfree_q     <= s_q;
				OP_RESULT:     out_valid_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	// request fields, walk pointers and result payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				req_q    <= in_req;
				a_q      <= in_author[AIW-1:0];
				label_q  <= in_label[LABEL_BITS-1:0];
				id_q     <= in_id[ID_BITS-1:0];
				inform_q <= in_inform;
			end
			OP_EV_START: begin
				e_q      <= ahead_rd_q;
				prev_e_q <= EV_NULL;
			end
			OP_EV_NEXT: begin
				prev_e_q <= e_q;
				e_q      <= elink_rd_q;
			end
			OP_EV_ALLOC:   e_q <= efree_q;
			OP_RM_EV_FREE: e_q <= elink_rd_q;
			OP_EV_LINK: begin
				s_q      <= SUB_NULL;
				prev_s_q <= SUB_NULL;
			end
			OP_SB_START: begin
				s_q      <= eshead_rd_q;
				prev_s_q <= SUB_NULL;
			end
			OP_SB_NEXT: begin
				prev_s_q <= s_q;
				s_q      <= slink_rd_q;
			end
			OP_SB_ALLOC:    s_q <= sfree_q;
			OP_RM_SB_START: s_q <= eshead_rd_q;
			OP_RM_SB_FREE:  s_q <= slink_rd_q;
			OP_RESULT: begin
				out_status_q <= cmd.code;
				out_notify_q <= notify;
				out_index_q  <= notify ? 8'(a_q) : 8'd0;
				out_source_q <= notify ? 16'(id_q) : 16'd0;
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_notify = out_notify_q;
	assign out_index  = out_index_q;
	assign out_source = out_source_q;

endmodule

// ===== sv/subscription_table_engine.sv =====
// ----------------------------------------------------------------------------
// subscription_table_engine
// m_tvalid after walking author events, then label subscribers; new entries appended,
// unlink splices out, duplicate/absent/full ends early; remove frees each event's subscribers,
// then the event; one request at a time; reset: clearing pass, s_tready low meanwhile
// ----------------------------------------------------------------------------
`include "subscription_table_engine_defines.svh"

module subscription_table_engine
	import ste_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // author_index, event_label, subscriber_id, inform_request
	input  logic [1:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // status, notify_author, notify_author_index, notify_source_id
);

	cmd_t  cmd;
	stat_t stat;
	logic [2:0]  out_status;
	logic        out_notify;
	logic [7:0]  out_index;
	logic [15:0] out_source;

	// sequencer
	ste_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// tables and result register
	ste_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_req     (s_tuser),
		.in_author  (s_tdata[7:0]),
		.in_label   (s_tdata[23:8]),
		.in_id      (s_tdata[39:24]),
		.in_inform  (s_tdata[40]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (out_status),
		.out_notify (out_notify),
		.out_index  (out_index),
		.out_source (out_source)
	);

	assign m_tdata = {4'd0, out_source, out_index, out_notify, out_status};

	// checks
	`STE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`STE_ASSERT_NOW(a_result_slot_free, cmd.op == OP_RESULT, !stat.out_full)
	`STE_ASSERT_NEXT(a_result_drained, m_tvalid && m_tready, !m_tvalid)

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// subscription table engine testbench
// streams subscribe, unsubscribe and remove-author requests into the engine,
// keeps its own copy of the event and subscriber pools with their free lists,
// and compares every result transfer field by field with the predicted one
// ----------------------------------------------------------------------------
module testbench;
	import ste_pkg::*;

	typedef struct {
		logic [1:0]  req;
		logic [7:0]  author;
		logic [15:0] label;
		logic [15:0] id;
		logic        inform;
	} request_t;

	typedef struct {
		status_t     status;
		logic        notify;
		logic [7:0]  notify_idx;
		logic [15:0] notify_src;
	} reply_t;

	localparam int QUIET_TAIL = 100;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // author_index, event_label, subscriber_id, inform_request
	logic [1:0]  s_tuser;   // req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // status, notify_author, notify_author_index, notify_source_id

	request_t pending_reqs[$];
	reply_t   expected_replies[$];
	request_t in_flight;
	int       total_reqs;
	int       accepted_reqs;
	int       replies_seen;
	int       errors;
	int       status_hits[8];
	bit       stim_ready;

	// shadow copy of the subscription tables
	logic [EPW-1:0]   author_head[AUTHOR_SLOTS];
	logic [EPW-1:0]   author_events[AUTHOR_SLOTS];
	logic [15:0]      event_label[EVENT_SLOTS];
	logic [EPW-1:0]   event_link[EVENT_SLOTS];
	logic [SPW-1:0]   event_subs[EVENT_SLOTS];
	logic [15:0]      sub_id[SUBSCRIBER_SLOTS];
	logic [SPW-1:0]   sub_link[SUBSCRIBER_SLOTS];
	logic [EPW-1:0]   event_free;
	logic [SPW-1:0]   sub_free;

	subscription_table_engine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#40ms;
		$display("timeout: %0d of %0d requests accepted, %0d replies", accepted_reqs,
			total_reqs, replies_seen);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------------
	// table model
	// ------------------------------------------------------------------------
	task automatic clear_tables();
		for (int i = 0; i < AUTHOR_SLOTS; i++) begin
			author_head[i]   = EV_NULL;
			author_events[i] = '0;
		end
		for (int i = 0; i < EVENT_SLOTS; i++) begin
			event_label[i] = '0;
			event_link[i]  = EPW'(i + 1);
			event_subs[i]  = SUB_NULL;
		end
		for (int i = 0; i < SUBSCRIBER_SLOTS; i++) begin
			sub_id[i]   = '0;
			sub_link[i] = SPW'(i + 1);
		end
		event_free = '0;
		sub_free   = '0;
	endtask

	// walk an author's events, returns the match or null plus the last record seen
	function automatic logic [EPW-1:0] find_label(input logic [7:0] a, input logic [15:0] lbl,
			output logic [EPW-1:0] last);
		logic [EPW-1:0] e;
		int n;
		e = author_head[a];
		last = EV_NULL;
		n = 0;
		while (e != EV_NULL && n < EVENT_SLOTS) begin
			if (event_label[e] == lbl)
				return e;
			last = e;
			e = event_link[e];
			n++;
		end
		return EV_NULL;
	endfunction

	function automatic status_t subscribe(input logic [7:0] a, input logic [15:0] lbl,
			input logic [15:0] id);
		logic [EPW-1:0] last;
		logic [EPW-1:0] e;
		logic [SPW-1:0] s;
		logic [SPW-1:0] prev;
		logic [SPW-1:0] fresh;
		int n;
		// add the label to the author when absent and a record is free
		if (event_free != EV_NULL && find_label(a, lbl, last) == EV_NULL) begin
			e = event_free;
			event_free = event_link[e];
			event_label[e] = lbl;
			event_link[e] = EV_NULL;
			event_subs[e] = SUB_NULL;
			if (last != EV_NULL)
				event_link[last] = e;
			else
				author_head[a] = e;
			author_events[a]++;
		end
		if (author_events[a] == 0)
			return ST_EVENT_FULL;
		e = find_label(a, lbl, last);
		if (e == EV_NULL)
			return ST_EVENT_FULL;
		s = event_subs[e];
		prev = SUB_NULL;
		n = 0;
		while (s != SUB_NULL && n < SUBSCRIBER_SLOTS) begin
			if (sub_id[s] == id)
				return ST_DUPLICATE;
			prev = s;
			s = sub_link[s];
			n++;
		end
		if (sub_free == SUB_NULL)
			return ST_SUB_FULL;
		fresh = sub_free;
		sub_free = sub_link[fresh];
		sub_id[fresh] = id;
		sub_link[fresh] = SUB_NULL;
		if (prev != SUB_NULL)
			sub_link[prev] = fresh;
		else
			event_subs[e] = fresh;
		return ST_DONE;
	endfunction

	function automatic status_t unsubscribe(input logic [7:0] a, input logic [15:0] lbl,
			input logic [15:0] id);
		logic [EPW-1:0] last;
		logic [EPW-1:0] e;
		logic [SPW-1:0] s;
		logic [SPW-1:0] prev;
		logic [SPW-1:0] rest;
		int n;
		if (author_events[a] == 0)
			return ST_EVENT_ABSENT;
		e = find_label(a, lbl, last);
		if (e == EV_NULL)
			return ST_EVENT_ABSENT;
		s = event_subs[e];
		prev = SUB_NULL;
		n = 0;
		while (s != SUB_NULL && n < SUBSCRIBER_SLOTS) begin
			if (sub_id[s] == id) begin
				rest = sub_link[s];
				sub_link[s] = sub_free;
				sub_free = s;
				if (prev != SUB_NULL)
					sub_link[prev] = rest;
				else
					event_subs[e] = rest;
				return ST_DONE;
			end
			prev = s;
			s = sub_link[s];
			n++;
		end
		return ST_SUB_ABSENT;
	endfunction

	function automatic void remove_author(input logic [7:0] a);
		logic [EPW-1:0] e;
		logic [EPW-1:0] enx;
		logic [SPW-1:0] s;
		logic [SPW-1:0] snx;
		int n;
		int m;
		if (author_events[a] != 0) begin
			// free every subscriber of every event first
			e = author_head[a];
			n = 0;
			while (e != EV_NULL && n < EVENT_SLOTS) begin
				s = event_subs[e];
				event_subs[e] = SUB_NULL;
				m = 0;
				while (s != SUB_NULL && m < SUBSCRIBER_SLOTS) begin
					snx = sub_link[s];
					sub_link[s] = sub_free;
					sub_free = s;
					s = snx;
					m++;
				end
				e = event_link[e];
				n++;
			end
			e = author_head[a];
			n = 0;
			while (e != EV_NULL && n < EVENT_SLOTS) begin
				enx = event_link[e];
				event_link[e] = event_free;
				event_free = e;
				e = enx;
				n++;
			end
		end
		author_events[a] = '0;
		author_head[a] = EV_NULL;
	endfunction

	function automatic reply_t predict_reply(input request_t r);
		reply_t rep;
		rep.status = ST_DONE;
		rep.notify = 1'b0;
		rep.notify_idx = '0;
		rep.notify_src = '0;
		case (r.req)
			REQ_SUBSCRIBE: begin
				rep.status = subscribe(r.author, r.label, r.id);
				if (rep.status == ST_DONE && r.inform) begin
					rep.notify = 1'b1;
					rep.notify_idx = r.author;
					rep.notify_src = r.id;
				end
			end
			REQ_UNSUBSCRIBE: rep.status = unsubscribe(r.author, r.label, r.id);
			REQ_REMOVE: remove_author(r.author);
			default: ;
		endcase
		return rep;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	task automatic push_req(input logic [1:0] req, input logic [7:0] a, input logic [15:0] lbl,
			input logic [15:0] id, input logic inf);
		request_t r;
		r.req = req;
		r.author = a;
		r.label = lbl;
		r.id = id;
		r.inform = inf;
		pending_reqs.push_back(r);
	endtask

	initial begin
		logic [15:0] label_pool[6];
		logic [15:0] id_pool[8];
		logic [7:0]  author_pool[5];
		logic [1:0]  req;
		int          pick;
		clear_tables();

		// directed: basic paths, duplicates, absences and field extremes
		push_req(REQ_UNSUBSCRIBE, 8'd3, 16'h0000, 16'h0000, 1'b0);
		push_req(REQ_SUBSCRIBE,   8'd3, 16'h0000, 16'h0000, 1'b1);
		push_req(REQ_SUBSCRIBE,   8'd3, 16'h0000, 16'h0000, 1'b1);
		push_req(REQ_SUBSCRIBE,   8'd3, 16'h0000, 16'hFFFF, 1'b0);
		push_req(REQ_SUBSCRIBE,   8'd3, 16'hFFFF, 16'hFFFF, 1'b1);
		push_req(REQ_SUBSCRIBE,   8'd255, 16'hFFFF, 16'h5A5A, 1'b1);
		push_req(REQ_SUBSCRIBE,   8'd255, 16'hA5A5, 16'hFFFF, 1'b1);
		push_req(REQ_UNSUBSCRIBE, 8'd3, 16'h1234, 16'h0000, 1'b1);
		push_req(REQ_UNSUBSCRIBE, 8'd3, 16'h0000, 16'h7777, 1'b0);
		push_req(REQ_UNSUBSCRIBE, 8'd3, 16'h0000, 16'h0000, 1'b0);
		push_req(REQ_UNSUBSCRIBE, 8'd3, 16'h0000, 16'hFFFF, 1'b0);
		push_req(REQ_UNSUBSCRIBE, 8'd3, 16'h0000, 16'hFFFF, 1'b0);
		push_req(REQ_SUBSCRIBE,   8'd3, 16'h0000, 16'h0001, 1'b1);
		push_req(REQ_REMOVE,      8'd0, 16'hFFFF, 16'hFFFF, 1'b1);
		push_req(REQ_REMOVE,      8'd3, 16'h0000, 16'h0000, 1'b0);
		push_req(REQ_UNSUBSCRIBE, 8'd3, 16'hFFFF, 16'hFFFF, 1'b0);
		push_req(REQ_SUBSCRIBE,   8'd3, 16'hFFFF, 16'h0002, 1'b1);
		push_req(REQ_REMOVE,      8'd255, 16'h0000, 16'h0000, 1'b0);
		push_req(REQ_UNSUBSCRIBE, 8'd255, 16'hFFFF, 16'h5A5A, 1'b0);

		// random mix, mostly over a few authors, labels and ids so lists collide
		label_pool[0] = 16'h0000;
		label_pool[1] = 16'hFFFF;
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		for (int i = 2; i < 6; i++) label_pool[i] = 16'($urandom);
		for (int i = 2; i < 8; i++) id_pool[i] = 16'($urandom);
		author_pool = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd255};
		for (int i = 0; i < 20; i++) begin
			pick = $urandom_range(0, 99);
			req = (pick < 55) ? REQ_SUBSCRIBE : (pick < 90) ? REQ_UNSUBSCRIBE : REQ_REMOVE;
			if ($urandom_range(0, 9) == 0)
				push_req(req, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
			else
				push_req(req, author_pool[$urandom_range(0, 4)],
					label_pool[$urandom_range(0, 5)], id_pool[$urandom_range(0, 7)],
					1'($urandom));
		end

		// exhaust the event pool, new labels spread over sixteen authors
		for (int i = 0; i < 264; i++)
			push_req(REQ_SUBSCRIBE, 8'(16 + i % 16), 16'(16'h1000 + i), 16'($urandom),
				1'($urandom));
		// exhaust the subscriber pool on labels that already exist
		for (int k = 0; k < 790; k++)
			push_req(REQ_SUBSCRIBE, 8'(16 + (k % 256) % 16), 16'(16'h1000 + k % 256),
				16'(16'h8000 + k), 1'($urandom));
		for (int i = 16; i < 32; i++)
			push_req(REQ_REMOVE, 8'(i), 16'($urandom), 16'($urandom), 1'($urandom));

		total_reqs = pending_reqs.size();
		stim_ready = 1'b1;
	end

	// ------------------------------------------------------------------------
	// request driver
	// ------------------------------------------------------------------------
	int drv_gap;

	always @(posedge clk or negedge arst_n) begin
		logic     next_valid;
		request_t next_req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			drv_gap  <= 0;
			accepted_reqs <= 0;
		end else begin
			next_valid = s_tvalid;
			// predict at acceptance, the engine handles one request at a time
			if (s_tvalid && s_tready) begin
				expected_replies.push_back(predict_reply(in_flight));
				accepted_reqs <= accepted_reqs + 1;
				next_valid = 1'b0;
			end
			if (!next_valid && stim_ready && pending_reqs.size() > 0) begin
				if (drv_gap > 0) begin
					drv_gap <= drv_gap - 1;
				end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
					drv_gap <= $urandom_range(1, 15);
				end else begin
					next_req = pending_reqs.pop_front();
					in_flight <= next_req;
					s_tdata <= {7'd0, next_req.inform, next_req.id, next_req.label,
						next_req.author};
					s_tuser <= next_req.req;
					next_valid = 1'b1;
				end
			end
			s_tvalid <= next_valid;
		end
	end

	// ------------------------------------------------------------------------
	// reply monitor
	// ------------------------------------------------------------------------
	int  mon_stall;
	bit  long_hold_done;

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		logic   next_ready;
		int     next_stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
			mon_stall <= 0;
			long_hold_done <= 1'b0;
			replies_seen <= 0;
		end else begin
			next_stall = mon_stall;
			if (m_tvalid && m_tready) begin
				replies_seen <= replies_seen + 1;
				status_hits[m_tdata[2:0]]++;
				if (expected_replies.size() == 0) begin
					$error("reply with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					want = expected_replies.pop_front();
					if (m_tdata[2:0] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
						errors++;
					end
					if (m_tdata[3] !== want.notify) begin
						$error("notify_author: expected %0d, got %0d", want.notify, m_tdata[3]);
						errors++;
					end
					if (m_tdata[11:4] !== want.notify_idx) begin
						$error("notify_author_index: expected %0d, got %0d", want.notify_idx,
							m_tdata[11:4]);
						errors++;
					end
					if (m_tdata[27:12] !== want.notify_src) begin
						$error("notify_source_id: expected %h, got %h", want.notify_src,
							m_tdata[27:12]);
						errors++;
					end
				end
				// one long hold-off while the sender keeps offering
				if (!long_hold_done && replies_seen == 60) begin
					next_stall = 400;
					long_hold_done <= 1'b1;
				end
			end
			if (next_stall > 0) begin
				next_stall--;
				next_ready = 1'b0;
			end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
				next_stall = $urandom_range(1, 15);
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			mon_stall <= next_stall;
			m_tready <= next_ready;
		end
	end

	// ------------------------------------------------------------------------
	// end of run
	// ------------------------------------------------------------------------
	initial begin
		wait (stim_ready);
		wait (accepted_reqs == total_reqs && expected_replies.size() == 0);
		repeat (200) @(posedge clk);
		$display("%0d requests, %0d replies; done %0d, duplicate %0d, event full %0d",
			accepted_reqs, replies_seen, status_hits[0], status_hits[1], status_hits[2]);
		$display("subscriber full %0d, event absent %0d, subscriber absent %0d",
			status_hits[3], status_hits[4], status_hits[5]);
		if (errors == 0 && expected_replies.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== subscription_table_engine.f =====
+incdir+sv
sv/ste_pkg.sv
sv/ste_ctrl.sv
sv/ste_datapath.sv
sv/subscription_table_engine.sv
sim/testbench.sv
